/* design/lcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_pkg: shared types for the LCS length engine
// Request codes, the token that moves along the cell chain, and the control
// group that the top level sends to every cell.
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int SYM_W = 8;
  localparam int OUT_W = 7;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_STREAM = 2'd1,
    REQ_FINISH = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] sym;
  } tok_t;

  typedef struct packed {
    logic             append;
    logic             clear;
    logic [SYM_W-1:0] sym;
  } cell_ctrl_t;

endpackage

/* design/lcs_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_cell: one position of the first string
// Holds one stored symbol and its table entry. A streamed symbol passes
// through as a token carrying the diagonal and left values; an occupied
// cell updates its entry and hands the token on the next cycle.
// ----------------------------------------------------------------------------
module lcs_cell #(
  parameter int VW = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lcs_pkg::cell_ctrl_t     ctrl,
  input  logic                    prev_used,
  output logic                    used,
  input  lcs_pkg::tok_t           tok_in,
  input  logic [VW-1:0]           diag_in,
  input  logic [VW-1:0]           left_in,
  output lcs_pkg::tok_t           tok_out,
  output logic [VW-1:0]           diag_out,
  output logic [VW-1:0]           left_out
);
  import lcs_pkg::*;

  logic [SYM_W-1:0] sym;
  logic [VW-1:0]    row;
  logic [VW-1:0]    cell_val;

  always_comb begin
    if (sym == tok_in.sym) begin
      cell_val = diag_in + VW'(1);
    end else if (row > left_in) begin
      cell_val = row;
    end else begin
      cell_val = left_in;
    end
  end

  always_ff @(posedge clk) begin
    tok_out.sym <= tok_in.sym;
    if (rst) begin
      used          <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
      if (ctrl.clear) begin
        used <= 1'b0;
      end else if (ctrl.append && prev_used && !used) begin
        used <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.append && prev_used && !used) begin
      sym <= ctrl.sym;
      row <= '0;
    end
    if (tok_in.valid && used) begin
      row      <= cell_val;
      diag_out <= row;
      left_out <= cell_val;
    end else begin
      diag_out <= diag_in;
      left_out <= left_in;
    end
  end

endmodule

/* design/lcs_length_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_length_engine: longest common subsequence length of two byte strings
// Loads the first string into a row of cells and streams the second string
// through them as a wavefront.
// ----------------------------------------------------------------------------
// A second-string symbol is taken every cycle; each one walks the chain of
// MAX_LEN cells one cell per cycle. An append or a finish beat waits until
// every streamed symbol has left the chain, and a finish also waits for the
// output register to be free. The final length of a pair is available in
// the cycle after the finish beat; the block is then clear for the next
// pair.
module lcs_length_engine #(
  parameter int MAX_LEN = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        req_type,
  input  logic [lcs_pkg::SYM_W-1:0]         symbol,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lcs_pkg::OUT_W-1:0]         lcs_length,
  output logic                              first_too_long
);
  import lcs_pkg::*;

  localparam int VW = $clog2(MAX_LEN + 1);
  localparam int CW = $clog2(MAX_LEN + 1);

  tok_t          tok  [MAX_LEN+1];
  logic [VW-1:0] diag [MAX_LEN+1];
  logic [VW-1:0] left [MAX_LEN+1];
  logic          used [MAX_LEN];

  cell_ctrl_t    ctrl;
  logic [CW-1:0] inflight;
  logic [VW-1:0] last_len;
  logic          overflow_seen;
  logic          accept;
  logic          full;
  req_t          req;

  assign req    = req_t'(req_type);
  assign full   = used[MAX_LEN-1];
  assign accept = in_valid && !in_stall;

  always_comb begin
    in_stall = 1'b0;
    unique case (req)
      REQ_APPEND: in_stall = (inflight != '0);
      REQ_FINISH: in_stall = (inflight != '0) || (out_valid && out_stall);
      REQ_STREAM: in_stall = 1'b0;
      REQ_NONE:   in_stall = 1'b0;
    endcase
  end

  always_comb begin
    ctrl.append = accept && (req == REQ_APPEND);
    ctrl.clear  = accept && (req == REQ_FINISH);
    ctrl.sym    = symbol;
  end

  assign tok[0].valid = accept && (req == REQ_STREAM);
  assign tok[0].sym   = symbol;
  assign diag[0]      = '0;
  assign left[0]      = '0;

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    logic prev_used;
    if (i == 0) begin : g_head
      assign prev_used = 1'b1;
    end else begin : g_body
      assign prev_used = used[i-1];
    end
    lcs_cell #(.VW(VW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .prev_used(prev_used),
      .used     (used[i]),
      .tok_in   (tok[i]),
      .diag_in  (diag[i]),
      .left_in  (left[i]),
      .tok_out  (tok[i+1]),
      .diag_out (diag[i+1]),
      .left_out (left[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight      <= '0;
      overflow_seen <= 1'b0;
      last_len      <= '0;
      out_valid     <= 1'b0;
    end else begin
      priority case ({tok[0].valid, tok[MAX_LEN].valid})
        2'b10:   inflight <= inflight + CW'(1);
        2'b01:   inflight <= inflight - CW'(1);
        default: inflight <= inflight;
      endcase
      if (tok[MAX_LEN].valid) begin
        last_len <= left[MAX_LEN];
      end
      if (ctrl.clear) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (ctrl.append) begin
        if (full) begin
          overflow_seen <= 1'b1;
        end else begin
          last_len <= '0;
        end
      end
      if (ctrl.clear) begin
        overflow_seen <= 1'b0;
        last_len      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      lcs_length     <= OUT_W'(last_len);
      first_too_long <= overflow_seen;
    end
  end

endmodule

/* design/lcs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_checker: port-level checks for the LCS length engine
// Watches the handshakes and result beats of the top level.
// ----------------------------------------------------------------------------
module lcs_checker #(
  parameter int MAX_LEN = 64
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [1:0]                req_type,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [lcs_pkg::OUT_W-1:0] lcs_length
);
  import lcs_pkg::*;

  logic finish_beat;
  assign finish_beat = in_valid && !in_stall && (req_type == REQ_FINISH);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat after reset");

  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid && out_stall) |-> $past(finish_beat))
    else $error("result beat without a finish beat");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && (MAX_LEN < 128) |-> (lcs_length <= MAX_LEN))
    else $error("length exceeds first string capacity");

endmodule

bind lcs_length_engine lcs_checker #(.MAX_LEN(MAX_LEN)) u_lcs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .req_type  (req_type),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .lcs_length(lcs_length)
);

/* verif/lcs_length_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_length_engine_tb: self-checking bench for the LCS length engine
// Drives request beats, tracks the first string and the table row of the
// current pair in the bench itself, and compares every emitted length and
// overflow flag with the value predicted when the finish beat was taken.
// Covers empty strings, symbol extremes, the ignored request code, appends
// after streaming, a full-length pair with overflow, output back-pressure,
// a drained pause, a stretch with no idling and random pairs.
// ----------------------------------------------------------------------------
module lcs_length_engine_tb;
  import lcs_pkg::*;

  localparam int MAX_LEN     = 64;
  localparam int QUIET_LIMIT = 3000;
  localparam int ITEM_TARGET = 1850;

  typedef struct {
    logic [OUT_W-1:0] len;
    logic             too_long;
  } pair_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       req_type = REQ_NONE;
  logic [SYM_W-1:0] symbol = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [OUT_W-1:0] lcs_length;
  logic             first_too_long;

  // bench copy of the pair state
  logic [SYM_W-1:0] first_syms [MAX_LEN];
  logic [OUT_W-1:0] lcs_row [MAX_LEN];
  int unsigned      first_count = 0;
  logic             overflow_flag = 1'b0;

  pair_result_t     lengths_due[$];

  int send_idle_pct = 38;
  int stall_pct     = 38;
  int hold_left     = 0;
  int beats_taken   = 0;
  int results_seen  = 0;
  int pairs_done    = 0;
  int overflow_pairs = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  lcs_length_engine #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .symbol        (symbol),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .lcs_length    (lcs_length),
    .first_too_long(first_too_long)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  function automatic void clear_pair_state();
    first_count   = 0;
    overflow_flag = 1'b0;
    for (int i = 0; i < MAX_LEN; i++) lcs_row[i] = '0;
  endfunction

  function automatic void advance_lcs_row(input logic [SYM_W-1:0] sym);
    logic [OUT_W-1:0] diag;
    logic [OUT_W-1:0] left_new;
    logic [OUT_W-1:0] up;
    logic [OUT_W-1:0] entry;
    diag     = '0;
    left_new = '0;
    for (int i = 0; i < first_count; i++) begin
      up = lcs_row[i];
      if (first_syms[i] == sym) entry = diag + 1'b1;
      else entry = (up > left_new) ? up : left_new;
      diag       = up;
      left_new   = entry;
      lcs_row[i] = entry;
    end
  endfunction

  function automatic void track_lcs_beat(input req_t kind, input logic [SYM_W-1:0] sym);
    pair_result_t res;
    case (kind)
      REQ_APPEND: begin
        if (first_count < MAX_LEN) begin
          first_syms[first_count] = sym;
          lcs_row[first_count]    = '0;
          first_count++;
        end else begin
          overflow_flag = 1'b1;
        end
      end
      REQ_STREAM: begin
        advance_lcs_row(sym);
      end
      REQ_FINISH: begin
        res.len      = (first_count > 0) ? lcs_row[first_count-1] : '0;
        res.too_long = overflow_flag;
        lengths_due.push_back(res);
        pairs_done++;
        if (overflow_flag) overflow_pairs++;
        clear_pair_state();
      end
      default: begin
      end
    endcase
  endfunction

  // take beats on both sides, check results, watch for a hang
  always @(posedge clk) begin
    pair_result_t want;
    logic         took_in;
    logic         took_out;
    took_in  = !rst && in_valid && !in_stall;
    took_out = !rst && out_valid && !out_stall;
    if (took_in) begin
      if (req_t'(req_type) != REQ_NONE) beats_taken++;
      track_lcs_beat(req_t'(req_type), symbol);
    end
    if (took_out) begin
      results_seen++;
      if (lengths_due.size() == 0) begin
        report_mismatch($sformatf("result %0d/%0b with no pair pending",
                                  lcs_length, first_too_long));
      end else begin
        want = lengths_due.pop_front();
        if (lcs_length !== want.len)
          report_mismatch($sformatf("lcs_length %0d, want %0d", lcs_length, want.len));
        if (first_too_long !== want.too_long)
          report_mismatch($sformatf("first_too_long %0b, want %0b",
                                    first_too_long, want.too_long));
      end
    end
    if (rst || took_in || took_out) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d cycles with no beat", quiet_cycles);
      $display("FAIL lcs_length_engine");
      $finish;
    end
  end

  // receiver: random stall, or a long hold when one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_beat(input req_t kind, input logic [SYM_W-1:0] sym);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    symbol   <= sym;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (lengths_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [SYM_W-1:0] pair_symbol(input logic [SYM_W-1:0] base);
    if ($urandom_range(99) < 80) return base ^ SYM_W'($urandom_range(3));
    return SYM_W'($urandom);
  endfunction

  task automatic maybe_noise();
    if ($urandom_range(99) < 3) send_beat(REQ_NONE, SYM_W'($urandom));
  endtask

  task automatic run_random_pair();
    int               n_first;
    int               n_second;
    int               pick;
    logic [SYM_W-1:0] base;
    pick = $urandom_range(99);
    if (pick < 6) n_first = $urandom_range(MAX_LEN + 6, MAX_LEN);
    else if (pick < 12) n_first = 0;
    else if (pick < 20) n_first = $urandom_range(MAX_LEN - 1, 20);
    else n_first = $urandom_range(12, 1);
    pick = $urandom_range(99);
    if (pick < 10) n_second = 0;
    else if (pick < 18) n_second = $urandom_range(48, 16);
    else n_second = $urandom_range(12, 1);
    base = SYM_W'($urandom);
    if ($urandom_range(99) < 8) send_beat(REQ_STREAM, pair_symbol(base));
    repeat (n_first) begin
      maybe_noise();
      send_beat(REQ_APPEND, pair_symbol(base));
    end
    repeat (n_second) begin
      maybe_noise();
      if ($urandom_range(99) < 4) send_beat(REQ_APPEND, pair_symbol(base));
      send_beat(REQ_STREAM, pair_symbol(base));
    end
    send_beat(REQ_FINISH, SYM_W'($urandom));
  endtask

  task automatic test_empty_strings();
    send_beat(REQ_FINISH, 8'h00);
    send_beat(REQ_APPEND, 8'h41);
    send_beat(REQ_APPEND, 8'h42);
    send_beat(REQ_FINISH, 8'hFF);
    send_beat(REQ_STREAM, 8'h41);
    send_beat(REQ_FINISH, 8'h00);
  endtask

  task automatic test_symbol_extremes();
    send_beat(REQ_APPEND, 8'h00);
    send_beat(REQ_APPEND, 8'hFF);
    send_beat(REQ_STREAM, 8'hFF);
    send_beat(REQ_STREAM, 8'h00);
    send_beat(REQ_FINISH, 8'hFF);
  endtask

  task automatic test_ignored_request();
    send_beat(REQ_NONE, 8'hFF);
    send_beat(REQ_APPEND, 8'h5A);
    send_beat(REQ_NONE, 8'h5A);
    send_beat(REQ_STREAM, 8'h5A);
    send_beat(REQ_NONE, 8'h00);
    send_beat(REQ_FINISH, 8'h00);
  endtask

  task automatic test_append_after_stream();
    send_beat(REQ_APPEND, 8'h41);
    send_beat(REQ_STREAM, 8'h42);
    send_beat(REQ_APPEND, 8'h42);
    send_beat(REQ_STREAM, 8'h41);
    send_beat(REQ_STREAM, 8'h42);
    send_beat(REQ_FINISH, 8'h00);
  endtask

  task automatic test_longest_strings();
    logic [SYM_W-1:0] text [MAX_LEN];
    for (int i = 0; i < MAX_LEN; i++) begin
      text[i] = SYM_W'($urandom);
      send_beat(REQ_APPEND, text[i]);
    end
    send_beat(REQ_APPEND, 8'hFF);
    for (int i = 0; i < MAX_LEN; i++) send_beat(REQ_STREAM, text[i]);
    send_beat(REQ_FINISH, 8'h00);
  endtask

  task automatic test_output_holdoff();
    send_idle_pct = 0;
    hold_left     = 400;
    repeat (8) begin
      send_beat(REQ_APPEND, SYM_W'($urandom_range(3)));
      send_beat(REQ_STREAM, SYM_W'($urandom_range(3)));
      send_beat(REQ_STREAM, SYM_W'($urandom_range(3)));
      send_beat(REQ_FINISH, 8'h00);
    end
    send_idle_pct = 38;
    wait_drained();
  endtask

  task automatic test_drain_pause();
    repeat (3) run_random_pair();
    wait_drained();
    repeat (3) run_random_pair();
  endtask

  task automatic test_back_to_back();
    int start;
    start         = beats_taken;
    send_idle_pct = 0;
    stall_pct     = 0;
    while (beats_taken - start < 250) run_random_pair();
    send_idle_pct = 38;
    stall_pct     = 38;
  endtask

  task automatic test_random_pairs();
    while (beats_taken < ITEM_TARGET) run_random_pair();
  endtask

  initial begin
    for (int i = 0; i < MAX_LEN; i++) first_syms[i] = '0;
    clear_pair_state();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_strings();
    test_symbol_extremes();
    test_ignored_request();
    test_append_after_stream();
    test_longest_strings();
    test_output_holdoff();
    test_drain_pause();
    test_back_to_back();
    test_random_pairs();

    wait_drained();
    repeat (MAX_LEN + 16) @(posedge clk);
    if (lengths_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", lengths_due.size()));

    $display("Ran %0d request beats over %0d string pairs, %0d of them with an over-long",
             beats_taken, pairs_done, overflow_pairs);
    $display("first string; %0d lengths checked, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS lcs_length_engine");
    end else begin
      $display("FAIL lcs_length_engine");
    end
    $finish;
  end

endmodule

/* lcs_length_engine.f */
design/lcs_pkg.sv
design/lcs_cell.sv
design/lcs_length_engine.sv
design/lcs_checker.sv
verif/lcs_length_engine_tb.sv
